// ----- rtl/accumulator_machine_execute_defines.svh -----
// Assertion macros for the accumulator machine execute block.
// Expects clk and rst_n in the scope of use.
`ifndef ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define AME_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ame: implication check failed");

// next-cycle implication, checked outside reset
`define AME_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ame: next-cycle check failed");

`endif

// ----- rtl/ame_pkg.sv -----
// Shared types and constants for the accumulator machine execute block.
// No dependencies.
package ame_pkg;

    localparam int DEF_PROGRAM_DEPTH = 256;
    localparam int DEF_SLOT_DEPTH    = 32;
    localparam int DEF_DATA_WIDTH    = 32;

    localparam int FUNC_W   = 3;
    localparam int OPND_W   = 10;
    localparam int PORT_DW  = 32;
    localparam int PC_OUT_W = 8;
    localparam int PLEN_W   = 9;
    localparam int SCNT_W   = 6;
    localparam int OPEN_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW   = 9;

    typedef enum logic [FUNC_W-1:0] {
        OP_INBOX,
        OP_OUTBOX,
        OP_ADD,
        OP_SUB,
        OP_COPYTO,
        OP_COPYFROM,
        OP_JUMPZ,
        OP_JUMP
    } op_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DONE,
        ST_ERROR
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROG_LEN,
        CFG_SLOT_COUNT,
        CFG_OP_ENABLE
    } cfg_reg_t;

    // one result word
    typedef struct packed {
        logic                  out_valid;
        logic [PORT_DW-1:0]    out_value;
        logic                  inbox_take;
        logic [PC_OUT_W-1:0]   next_pc;
        status_t               run_status;
    } res_t;

endpackage

// ----- rtl/accumulator_machine_execute.sv -----
// Accumulator machine execute block: config registers, operand stage, result register.
// Depends on ame_pkg, ame_slot_mem, ame_exec and the assertion macro header.
//
// Usage:
//  - item channel (item_valid/item_ready) carries one instruction word with the
//    inbox front; result channel (result_valid/result_ready) returns one word per item.
//  - cfg channel writes program_length, slot_count, opcode_enable by index; always ready.
//    Write it only while no word is in flight.
//  - A word accepted is read from slot memory into the operand stage, then executed
//    into the result register.
//  - Throughput: one word per cycle while the receiver keeps up, set by the single
//    read and write port of the slot memory; a copyto then a same-slot read is forwarded.
//  - Reset clears pc, accumulator, holding flag, slot written bits and run status;
//    config returns to length 1, no slots, all opcodes disabled.
//  - When the receiver stalls, the result register holds, the operand stage fills,
//    and item_ready drops; no word is lost.
//  - Once halted, later words return the held pc and status and change nothing.
`include "accumulator_machine_execute_defines.svh"

module accumulator_machine_execute
    import ame_pkg::*;
#(
    parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
    parameter int SLOT_DEPTH    = DEF_SLOT_DEPTH,
    parameter int DATA_WIDTH    = DEF_DATA_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DW-1:0]          cfg_data,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [FUNC_W-1:0]          func,
    input  logic [OPND_W-1:0]          operand,
    input  logic                       operand_bad,
    input  logic                       inbox_has,
    input  logic signed [PORT_DW-1:0]  inbox_value,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic                       out_valid,
    output logic signed [PORT_DW-1:0]  out_value,
    output logic                       inbox_take,
    output logic [PC_OUT_W-1:0]        next_pc,
    output logic [1:0]                 run_status
);

    localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

    logic [PLEN_W-1:0] plen_reg;
    logic [SCNT_W-1:0] scnt_reg;
    logic [OPEN_W-1:0] open_reg;

    logic                  s1_valid_reg;
    logic [FUNC_W-1:0]     s1_func_reg;
    logic [OPND_W-1:0]     s1_opnd_reg;
    logic                  s1_bad_reg;
    logic                  s1_has_reg;
    logic [DATA_WIDTH-1:0] s1_ival_reg;
    logic                  fwd_hit_reg;
    logic [DATA_WIDTH-1:0] fwd_data_reg;

    res_t res_reg;
    res_t res_c;
    logic res_valid_reg;

    logic                  accept;
    logic                  fire;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] mem_word;
    logic [DATA_WIDTH-1:0] slot_word;

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg <= PLEN_W'(1);
            scnt_reg <= '0;
            open_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PROG_LEN:   plen_reg <= cfg_data[PLEN_W-1:0];
                CFG_SLOT_COUNT: scnt_reg <= cfg_data[SCNT_W-1:0];
                CFG_OP_ENABLE:  open_reg <= cfg_data[OPEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // execute when the result register is free or being drained
    assign fire       = s1_valid_reg && (!res_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || fire;
    assign accept     = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item_ready)
            s1_valid_reg <= item_valid;
    end

    // operand stage payload; catch a copyto to the slot being read this cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= func;
            s1_opnd_reg  <= operand;
            s1_bad_reg   <= operand_bad;
            s1_has_reg   <= inbox_has;
            s1_ival_reg  <= DATA_WIDTH'(inbox_value);
            fwd_hit_reg  <= wr_en && (wr_addr == operand[AW-1:0]);
            fwd_data_reg <= wr_data;
        end
    end

    ame_slot_mem #(
        .DEPTH (SLOT_DEPTH),
        .AW    (AW),
        .DW    (DATA_WIDTH)
    ) u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (operand[AW-1:0]),
        .rd_data (mem_word),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign slot_word = fwd_hit_reg ? fwd_data_reg : mem_word;

    ame_exec #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .SLOT_DEPTH    (SLOT_DEPTH),
        .DATA_WIDTH    (DATA_WIDTH),
        .AW            (AW)
    ) u_exec (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .func           (s1_func_reg),
        .operand        (s1_opnd_reg),
        .operand_bad    (s1_bad_reg),
        .inbox_has      (s1_has_reg),
        .inbox_word     (s1_ival_reg),
        .slot_word      (slot_word),
        .program_length (plen_reg),
        .slot_count     (scnt_reg),
        .opcode_enable  (open_reg),
        .res            (res_c),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (fire)
            res_valid_reg <= 1'b1;
        else if (result_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_c;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_valid    = res_reg.out_valid;
    assign out_value    = res_reg.out_value;
    assign inbox_take   = res_reg.inbox_take;
    assign next_pc      = res_reg.next_pc;
    assign run_status   = res_reg.run_status;

    // an outbox on the last instruction emits and finishes in the same word
    `AME_ASSERT_IMP(a_stall_cause, !item_ready, s1_valid_reg && res_valid_reg && !result_ready)
    `AME_ASSERT_NXT(a_stage_holds, s1_valid_reg && !fire, s1_valid_reg)
    `AME_ASSERT_IMP(a_one_side_effect, res_valid_reg, !(res_reg.inbox_take && res_reg.out_valid))
    `AME_ASSERT_IMP(a_halt_quiet, res_valid_reg && (res_reg.run_status == ST_ERROR), !res_reg.out_valid)

endmodule

// ----- rtl/ame_slot_mem.sv -----
// Scratch slot store: one write port, one registered read port.
// Uses no package items.
module ame_slot_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read-before-write; the caller forwards same-cycle writes
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/ame_exec.sv -----
// Execute stage: architectural registers and instruction checks.
// Depends on ame_pkg.
module ame_exec
    import ame_pkg::*;
#(
    parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
    parameter int SLOT_DEPTH    = DEF_SLOT_DEPTH,
    parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
    parameter int AW            = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [FUNC_W-1:0]     func,
    input  logic [OPND_W-1:0]     operand,
    input  logic                  operand_bad,
    input  logic                  inbox_has,
    input  logic [DATA_WIDTH-1:0] inbox_word,
    input  logic [DATA_WIDTH-1:0] slot_word,
    input  logic [PLEN_W-1:0]     program_length,
    input  logic [SCNT_W-1:0]     slot_count,
    input  logic [OPEN_W-1:0]     opcode_enable,
    output res_t                  res,
    output logic                  wr_en,
    output logic [AW-1:0]         wr_addr,
    output logic [DATA_WIDTH-1:0] wr_data
);

    localparam int PC_W  = $clog2(PROGRAM_DEPTH);
    localparam int LEN_W = $clog2(PROGRAM_DEPTH + 1);
    localparam int CW    = (LEN_W > OPND_W) ? LEN_W : OPND_W;
    localparam int SLW   = $clog2(SLOT_DEPTH + 1);
    localparam int SCW   = (SLW > OPND_W) ? SLW : OPND_W;

    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic                  hold_reg, hold_next;
    status_t               halt_reg, halt_next;
    logic [SLOT_DEPTH-1:0] written_reg;
    logic                  copy_wr;

    logic [CW-1:0]  len_eff;
    logic [SCW-1:0] slots_eff;
    logic           slot_ok;
    logic           slot_valid;
    logic           target_ok;
    logic           ok;
    logic           jumped;
    logic [AW-1:0]  sidx;

    always_comb
    begin
        if (program_length == '0)
            len_eff = CW'(1);
        else if (CW'(program_length) > CW'(PROGRAM_DEPTH))
            len_eff = CW'(PROGRAM_DEPTH);
        else
            len_eff = CW'(program_length);

        if (SCW'(slot_count) > SCW'(SLOT_DEPTH))
            slots_eff = SCW'(SLOT_DEPTH);
        else
            slots_eff = SCW'(slot_count);
    end

    assign sidx       = operand[AW-1:0];
    assign slot_ok    = SCW'(operand) < slots_eff;
    assign slot_valid = slot_ok && written_reg[sidx];
    assign target_ok  = (operand != '0) && (CW'(operand) <= len_eff);

    always_comb
    begin
        pc_next   = pc_reg;
        acc_next  = acc_reg;
        hold_next = hold_reg;
        halt_next = halt_reg;
        copy_wr   = 1'b0;
        ok        = 1'b1;
        jumped    = 1'b0;
        res.out_valid  = 1'b0;
        res.out_value  = '0;
        res.inbox_take = 1'b0;

        if (halt_reg == ST_RUN)
        begin
            if (operand_bad || !opcode_enable[func])
            begin
                ok = 1'b0;
            end
            else
            begin
                unique case (op_t'(func))
                    OP_INBOX:
                    begin
                        if (!inbox_has)
                        begin
                            halt_next = ST_DONE;
                        end
                        else
                        begin
                            hold_next      = 1'b1;
                            acc_next       = inbox_word;
                            res.inbox_take = 1'b1;
                        end
                    end
                    OP_OUTBOX:
                    begin
                        if (!hold_reg)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            res.out_valid = 1'b1;
                            res.out_value = PORT_DW'(acc_reg);
                            hold_next     = 1'b0;
                            acc_next      = '0;
                        end
                    end
                    OP_ADD, OP_SUB:
                    begin
                        if (!slot_valid || !hold_reg)
                            ok = 1'b0;
                        else if (op_t'(func) == OP_ADD)
                            acc_next = acc_reg + slot_word;
                        else
                            acc_next = acc_reg - slot_word;
                    end
                    OP_COPYTO:
                    begin
                        if (!hold_reg || !slot_ok)
                            ok = 1'b0;
                        else
                            copy_wr = 1'b1;
                    end
                    OP_COPYFROM:
                    begin
                        if (!slot_valid)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            hold_next = 1'b1;
                            acc_next  = slot_word;
                        end
                    end
                    OP_JUMPZ:
                    begin
                        if (!target_ok || !hold_reg)
                        begin
                            ok = 1'b0;
                        end
                        else if (acc_reg == '0)
                        begin
                            pc_next = PC_W'(CW'(operand) - CW'(1));
                            jumped  = 1'b1;
                        end
                    end
                    OP_JUMP:
                    begin
                        if (!target_ok)
                        begin
                            ok = 1'b0;
                        end
                        else
                        begin
                            pc_next = PC_W'(CW'(operand) - CW'(1));
                            jumped  = 1'b1;
                        end
                    end
                endcase
            end

            if (!ok)
            begin
                halt_next      = ST_ERROR;
                res.inbox_take = 1'b0;
            end
            else if (halt_next == ST_RUN && !jumped)
            begin
                if (CW'(pc_reg) + CW'(1) >= len_eff)
                    halt_next = ST_DONE;
                else
                    pc_next = pc_reg + PC_W'(1);
            end
        end

        res.next_pc    = PC_OUT_W'(pc_next);
        res.run_status = halt_next;
    end

    assign wr_en   = fire && copy_wr;
    assign wr_addr = sidx;
    assign wr_data = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            acc_reg     <= '0;
            hold_reg    <= 1'b0;
            halt_reg    <= ST_RUN;
            written_reg <= '0;
        end
        else if (fire)
        begin
            pc_reg   <= pc_next;
            acc_reg  <= acc_next;
            hold_reg <= hold_next;
            halt_reg <= halt_next;
            if (copy_wr)
            begin
                written_reg[sidx] <= 1'b1;
            end
        end
    end

endmodule

// ----- tb/accumulator_machine_execute_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for accumulator_machine_execute: directed table, then long legal programs
// checked against an in-bench machine model, then a single halt and post-halt traffic.
// Depends on ame_pkg and the block's RTL only.
module accumulator_machine_execute_test;
    import ame_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        op_t         f;
        logic [9:0]  opnd;
        logic        has;
        logic [31:0] val;
        bit          typed;
        res_t        want;
    } plan_row_t;

    typedef enum {
        HALT_MALFORMED,
        HALT_DISABLED,
        HALT_NOT_HELD,
        HALT_SLOT_RANGE,
        HALT_TARGET_ZERO,
        HALT_TARGET_HIGH,
        HALT_INBOX_EMPTY,
        HALT_PROGRAM_END
    } halt_cause_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DW-1:0]         cfg_data;
    logic                      item_valid;
    logic                      item_ready;
    logic [FUNC_W-1:0]         func;
    logic [OPND_W-1:0]         operand;
    logic                      operand_bad;
    logic                      inbox_has;
    logic signed [PORT_DW-1:0] inbox_value;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    logic                      out_valid;
    logic signed [PORT_DW-1:0] out_value;
    logic                      inbox_take;
    logic [PC_OUT_W-1:0]       next_pc;
    logic [1:0]                run_status;

    // machine model state and register copies
    logic [7:0]  mach_pc;
    logic [31:0] mach_acc;
    logic        mach_held;
    logic [31:0] slot_val [32];
    logic        slot_set [32];
    status_t     mach_status;
    logic [8:0]  cfg_len;
    logic [5:0]  cfg_slots;
    logic [7:0]  cfg_en;

    res_t        pending_results [$];
    int          errors;
    int          n_items;
    int          n_checked;
    int          n_outbox;
    int          n_configs;
    int          gap_pct;
    int          stall_pct;
    int          stall_left;
    int          quiet_cycles;
    halt_cause_t cause;

    accumulator_machine_execute dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .operand      (operand),
        .operand_bad  (operand_bad),
        .inbox_has    (inbox_has),
        .inbox_value  (inbox_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_valid    (out_valid),
        .out_value    (out_value),
        .inbox_take   (inbox_take),
        .next_pc      (next_pc),
        .run_status   (run_status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int program_span();
        if (cfg_len == 9'd0)
            return 1;
        if (int'(cfg_len) > DEF_PROGRAM_DEPTH)
            return DEF_PROGRAM_DEPTH;
        return int'(cfg_len);
    endfunction

    function automatic int slots_in_use();
        return (int'(cfg_slots) > DEF_SLOT_DEPTH) ? DEF_SLOT_DEPTH : int'(cfg_slots);
    endfunction

    // one instruction against the model; updates the model state
    function automatic res_t execute_instruction(op_t f, logic [9:0] opnd, logic bad,
                                                 logic has, logic [31:0] val);
        res_t r;
        int   len;
        bit   slot_ok;
        bit   jumped;
        bit   fail;
        r       = '0;
        len     = program_span();
        slot_ok = int'(opnd) < slots_in_use();
        jumped  = 1'b0;
        fail    = 1'b0;
        if (mach_status == ST_RUN)
        begin
            if (bad || !cfg_en[f])
                fail = 1'b1;
            else
            begin
                case (f)
                    OP_INBOX:
                        if (!has)
                            mach_status = ST_DONE;
                        else
                        begin
                            mach_held    = 1'b1;
                            mach_acc     = val;
                            r.inbox_take = 1'b1;
                        end
                    OP_OUTBOX:
                        if (!mach_held)
                            fail = 1'b1;
                        else
                        begin
                            r.out_valid = 1'b1;
                            r.out_value = mach_acc;
                            mach_held   = 1'b0;
                            mach_acc    = '0;
                        end
                    OP_ADD, OP_SUB:
                        if (!slot_ok || !slot_set[opnd[4:0]] || !mach_held)
                            fail = 1'b1;
                        else if (f == OP_ADD)
                            mach_acc = mach_acc + slot_val[opnd[4:0]];
                        else
                            mach_acc = mach_acc - slot_val[opnd[4:0]];
                    OP_COPYTO:
                        if (!mach_held || !slot_ok)
                            fail = 1'b1;
                        else
                        begin
                            slot_set[opnd[4:0]] = 1'b1;
                            slot_val[opnd[4:0]] = mach_acc;
                        end
                    OP_COPYFROM:
                        if (!slot_ok || !slot_set[opnd[4:0]])
                            fail = 1'b1;
                        else
                        begin
                            mach_held = 1'b1;
                            mach_acc  = slot_val[opnd[4:0]];
                        end
                    OP_JUMPZ:
                        if (opnd == 10'd0 || int'(opnd) > len || !mach_held)
                            fail = 1'b1;
                        else if (mach_acc == 32'd0)
                        begin
                            mach_pc = 8'(opnd - 10'd1);
                            jumped  = 1'b1;
                        end
                    default:
                        if (opnd == 10'd0 || int'(opnd) > len)
                            fail = 1'b1;
                        else
                        begin
                            mach_pc = 8'(opnd - 10'd1);
                            jumped  = 1'b1;
                        end
                endcase
            end
            if (fail)
                mach_status = ST_ERROR;
            else if (mach_status == ST_RUN && !jumped)
            begin
                // running off the end, shortened program included, finishes cleanly
                if (int'(mach_pc) + 1 >= len)
                    mach_status = ST_DONE;
                else
                    mach_pc = mach_pc + 8'd1;
            end
        end
        r.next_pc    = mach_pc;
        r.run_status = mach_status;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // keep slot reads off entries that were never written (slot 0 is written early on)
    function automatic logic [9:0] safe_operand(op_t f, logic [9:0] o);
        if ((f == OP_ADD || f == OP_SUB || f == OP_COPYFROM) && o < 10'd32 && !slot_set[o[4:0]])
            return 10'd0;
        return o;
    endfunction

    function automatic plan_row_t row(op_t f, int opnd, bit has, logic [31:0] v, bit typed,
                                      bit ov, logic [31:0] oval, bit take, int pc);
        plan_row_t r;
        r.f                 = f;
        r.opnd              = 10'(opnd);
        r.has               = has;
        r.val               = v;
        r.typed             = typed;
        r.want.out_valid    = ov;
        r.want.out_value    = oval;
        r.want.inbox_take   = take;
        r.want.next_pc      = 8'(pc);
        r.want.run_status   = ST_RUN;
        return r;
    endfunction

    task automatic issue(op_t f, logic [9:0] opnd, logic bad, logic has, logic [31:0] val,
                         bit typed = 1'b0, res_t want = '0);
        int   gap;
        res_t predicted;
        gap = (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 6) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid  <= 1'b1;
        func        <= f;
        operand     <= opnd;
        operand_bad <= bad;
        inbox_has   <= has;
        inbox_value <= val;
        do @(posedge clk); while (!item_ready);
        predicted = execute_instruction(f, opnd, bad, has, val);
        pending_results.push_back(typed ? want : predicted);
        n_items++;
    endtask

    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        drain();
        // let the last word clear the operand stage and the result register
        repeat (3) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DW'(val);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_PROG_LEN:   cfg_len   = 9'(val);
            CFG_SLOT_COUNT: cfg_slots = 6'(val);
            CFG_OP_ENABLE:  cfg_en    = 8'(val);
            default:        ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int len, int slots, int en);
        write_reg(CFG_PROG_LEN, len);
        write_reg(CFG_SLOT_COUNT, slots);
        write_reg(CFG_OP_ENABLE, en);
        n_configs++;
    endtask

    // legal instruction for the current model state, so the program keeps running
    task automatic pick_legal(output op_t f, output logic [9:0] opnd, output logic has,
                              output logic [31:0] val);
        op_t cand [$];
        int  filled [$];
        int  len;
        int  ns;
        bit  at_end;
        len    = program_span();
        ns     = slots_in_use();
        at_end = int'(mach_pc) + 1 >= len;
        for (int i = 0; i < ns; i++)
            if (slot_set[i])
                filled.push_back(i);
        if (cfg_en[OP_JUMP])
            cand.push_back(OP_JUMP);
        if (cfg_en[OP_JUMPZ] && mach_held && (!at_end || mach_acc == 32'd0))
            cand.push_back(OP_JUMPZ);
        if (!at_end)
        begin
            if (cfg_en[OP_INBOX])
                cand.push_back(OP_INBOX);
            if (cfg_en[OP_OUTBOX] && mach_held)
                cand.push_back(OP_OUTBOX);
            if (cfg_en[OP_ADD] && mach_held && filled.size() > 0)
                cand.push_back(OP_ADD);
            if (cfg_en[OP_SUB] && mach_held && filled.size() > 0)
                cand.push_back(OP_SUB);
            if (cfg_en[OP_COPYTO] && mach_held && ns > 0)
                cand.push_back(OP_COPYTO);
            if (cfg_en[OP_COPYFROM] && filled.size() > 0)
                cand.push_back(OP_COPYFROM);
        end
        f    = cand[$urandom_range(0, cand.size() - 1)];
        has  = 1'($urandom_range(0, 1));
        val  = pick_value();
        opnd = 10'($urandom_range(0, 1023));
        case (f)
            OP_INBOX:                    has  = 1'b1;
            OP_ADD, OP_SUB, OP_COPYFROM: opnd = 10'(filled[$urandom_range(0, filled.size() - 1)]);
            OP_COPYTO:                   opnd = 10'($urandom_range(0, ns - 1));
            OP_JUMP, OP_JUMPZ:           opnd = 10'($urandom_range(1, len));
            default:                     ;
        endcase
    endtask

    task automatic run_program(int count);
        op_t         f;
        logic [9:0]  opnd;
        logic        has;
        logic [31:0] val;
        for (int i = 0; i < count; i++)
        begin
            pick_legal(f, opnd, has, val);
            issue(f, opnd, 1'b0, has, val);
        end
    endtask

    task automatic send_noise(int count);
        op_t f;
        for (int i = 0; i < count; i++)
        begin
            f = op_t'($urandom_range(0, 7));
            issue(f, safe_operand(f, 10'($urandom_range(0, 1023))), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), pick_value());
        end
    endtask

    // result side: bursts of back-pressure
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left = $urandom_range(0, 5);
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        res_t want;
        res_t got;
        if (rst_n && result_valid && result_ready)
        begin
            got.out_valid  = out_valid;
            got.out_value  = out_value;
            got.inbox_take = inbox_take;
            got.next_pc    = next_pc;
            got.run_status = status_t'(run_status);
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none expected: pc %0d status %0d",
                         $time, next_pc, run_status);
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                if (got.out_valid)
                    n_outbox++;
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: word %0d expected out=%0b/%h take=%0b pc=%0d st=%0d",
                             $time, n_checked, want.out_valid, want.out_value,
                             want.inbox_take, want.next_pc, want.run_status);
                    $display("%0t: word %0d actual   out=%0b/%h take=%0b pc=%0d st=%0d",
                             $time, n_checked, got.out_valid, got.out_value,
                             got.inbox_take, got.next_pc, got.run_status);
                end
            end
        end
    end

    // watchdog on handshakes
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (cfg_valid && cfg_ready)
            || (result_valid && result_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        plan_row_t   plan [22];
        op_t         f;
        logic [9:0]  opnd;
        int          len;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_PROG_LEN;
        cfg_data    = '0;
        item_valid  = 1'b0;
        func        = '0;
        operand     = '0;
        operand_bad = 1'b0;
        inbox_has   = 1'b0;
        inbox_value = '0;
        mach_pc     = '0;
        mach_acc    = '0;
        mach_held   = 1'b0;
        mach_status = ST_RUN;
        cfg_len     = 9'd1;
        cfg_slots   = 6'd0;
        cfg_en      = 8'd0;
        for (int i = 0; i < 32; i++)
        begin
            slot_val[i] = '0;
            slot_set[i] = 1'b0;
        end
        errors       = 0;
        n_items      = 0;
        n_checked    = 0;
        n_outbox     = 0;
        n_configs    = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        gap_pct      = 25;
        stall_pct    = 25;

        // wrap, extremes and both jump kinds, then back to the start
        plan = '{
            row(OP_INBOX,    0,    1, 32'h7FFF_FFFF, 1, 0, 32'h0,         1, 1),
            row(OP_COPYTO,   0,    0, 32'h0,         1, 0, 32'h0,         0, 2),
            row(OP_ADD,      0,    0, 32'h0,         1, 0, 32'h0,         0, 3),
            row(OP_OUTBOX,   1023, 1, 32'hFFFF_FFFF, 1, 1, 32'hFFFF_FFFE, 0, 4),
            row(OP_INBOX,    512,  1, 32'h8000_0000, 1, 0, 32'h0,         1, 5),
            row(OP_COPYTO,   31,   0, 32'h0,         1, 0, 32'h0,         0, 6),
            row(OP_SUB,      0,    0, 32'h0,         1, 0, 32'h0,         0, 7),
            row(OP_OUTBOX,   0,    0, 32'h0,         1, 1, 32'h0000_0001, 0, 8),
            row(OP_COPYFROM, 31,   0, 32'h0,         1, 0, 32'h0,         0, 9),
            row(OP_SUB,      31,   0, 32'h0,         1, 0, 32'h0,         0, 10),
            row(OP_JUMPZ,    256,  0, 32'h0,         1, 0, 32'h0,         0, 255),
            row(OP_JUMP,     1,    0, 32'hFFFF_FFFF, 1, 0, 32'h0,         0, 0),
            row(OP_INBOX,    1023, 1, 32'hFFFF_FFFF, 1, 0, 32'h0,         1, 1),
            row(OP_JUMPZ,    5,    1, 32'h0,         1, 0, 32'h0,         0, 2),
            row(OP_ADD,      31,   0, 32'h0,         1, 0, 32'h0,         0, 3),
            row(OP_OUTBOX,   7,    0, 32'h0,         1, 1, 32'h7FFF_FFFF, 0, 4),
            row(OP_COPYFROM, 0,    0, 32'h0,         1, 0, 32'h0,         0, 5),
            row(OP_JUMP,     256,  0, 32'h0,         1, 0, 32'h0,         0, 255),
            row(OP_JUMP,     2,    0, 32'h0,         1, 0, 32'h0,         0, 1),
            row(OP_INBOX,    3,    1, 32'h0,         0, 0, 32'h0,         0, 0),
            row(OP_JUMPZ,    3,    0, 32'h0,         1, 0, 32'h0,         0, 2),
            row(OP_COPYTO,   16,   1, 32'h1234_5678, 0, 0, 32'h0,         0, 0)
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_config(256, 32, 8'hFF);
        foreach (plan[i])
            issue(plan[i].f, plan[i].opnd, 1'b0, plan[i].has, plan[i].val,
                  plan[i].typed, plan[i].want);

        for (int p = 0; p < 8; p++)
        begin
            // jump is always enabled so a legal word always exists
            case (p)
                0:       set_config(511, 63, 8'hFF);
                1:       set_config(1, 0, 8'h80);
                2:       set_config(0, 5, $urandom_range(0, 255) | 8'h80);
                default: set_config($urandom_range(2, 256), $urandom_range(1, 32),
                                    $urandom_range(0, 255) | 8'h80);
            endcase
            gap_pct   = (p % 3 == 1 || p == 7) ? 0 : 30;
            stall_pct = gap_pct;
            run_program((p == 1 || p == 2) ? 40 : 90);
            if (p == 3)
                drain();
            if (p != 1 && p != 2)
                run_program(80);
        end

        // the one halt of the run
        cause = halt_cause_t'($urandom_range(0, 7));
        set_config(511, 63, 8'hFF);
        case (cause)
            HALT_MALFORMED:
            begin
                f = op_t'($urandom_range(0, 7));
                issue(f, safe_operand(f, 10'($urandom_range(0, 1023))), 1'b1,
                      1'($urandom_range(0, 1)), pick_value());
            end
            HALT_DISABLED:
            begin
                write_reg(CFG_OP_ENABLE, 0);
                f = op_t'($urandom_range(0, 7));
                issue(f, safe_operand(f, 10'($urandom_range(0, 1023))), 1'b0,
                      1'($urandom_range(0, 1)), pick_value());
            end
            HALT_NOT_HELD:
            begin
                if (mach_pc == 8'd255)
                    issue(OP_JUMP, 10'd1, 1'b0, 1'b0, pick_value());
                if (mach_held)
                    issue(OP_OUTBOX, 10'($urandom_range(0, 1023)), 1'b0, 1'b1, pick_value());
                if ($urandom_range(0, 1) == 1)
                    issue(OP_OUTBOX, 10'($urandom_range(0, 1023)), 1'b0, 1'b1, pick_value());
                else
                    issue(OP_COPYTO, 10'($urandom_range(0, 31)), 1'b0, 1'b1, pick_value());
            end
            HALT_SLOT_RANGE:
            begin
                write_reg(CFG_SLOT_COUNT, $urandom_range(0, 63));
                issue(op_t'($urandom_range(OP_ADD, OP_COPYFROM)),
                      10'($urandom_range(slots_in_use(), 1023)), 1'b0, 1'b1, pick_value());
            end
            HALT_TARGET_ZERO:
                issue($urandom_range(0, 1) == 1 ? OP_JUMP : OP_JUMPZ, 10'd0, 1'b0, 1'b0,
                      pick_value());
            HALT_TARGET_HIGH:
            begin
                write_reg(CFG_PROG_LEN, $urandom_range(0, 511));
                len = program_span();
                issue($urandom_range(0, 1) == 1 ? OP_JUMP : OP_JUMPZ,
                      10'($urandom_range(len + 1, 1023)), 1'b0, 1'b1, pick_value());
            end
            HALT_INBOX_EMPTY:
                issue(OP_INBOX, 10'($urandom_range(0, 1023)), 1'b0, 1'b0, pick_value());
            default:
            begin
                // length at most the current pc plus one, the shortened-program case
                write_reg(CFG_PROG_LEN, $urandom_range(0, int'(mach_pc) + 1));
                issue(OP_INBOX, 10'($urandom_range(0, 1023)), 1'b0, 1'b1, pick_value());
            end
        endcase

        // halted: everything after this must leave the machine as it is
        send_noise(40);
        set_config($urandom_range(0, 511), $urandom_range(0, 63), 0);
        send_noise(40);

        drain();
        repeat (4) @(posedge clk);
        $display("Checked %0d of %0d words over %0d register settings, %0d outbox words.",
                 n_checked, n_items, n_configs, n_outbox);
        $display("Program ended by %s, with 80 words sent after the halt.", cause.name());
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ame_pkg.sv
rtl/ame_slot_mem.sv
rtl/ame_exec.sv
rtl/accumulator_machine_execute.sv
tb/accumulator_machine_execute_test.sv
